@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the standard clk_i and rst_ni.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/prq_pkg.sv @@
// Package with the types and constants of the priority ready queue.
package prq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 8;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned EntryCntW  = 5;
  localparam int unsigned StatusW    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

@@ rtl/prq_req_if.sv @@
// Request channel of the priority ready queue.
interface prq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [prq_pkg::IdW-1:0]     proc_id;
  logic [prq_pkg::PrioW-1:0]   proc_priority;

  modport source (output valid, cmd, proc_id, proc_priority, input ready);
  modport sink (input valid, cmd, proc_id, proc_priority, output ready);
endinterface

@@ rtl/prq_rsp_if.sv @@
// Result channel of the priority ready queue.
interface prq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            pop_valid;
  logic [prq_pkg::IdW-1:0]         popped_id;
  logic [prq_pkg::PrioW-1:0]       popped_priority;
  logic [prq_pkg::StatusW-1:0]     status_code;
  logic [prq_pkg::EntryCntW-1:0]   entry_count;

  modport source (output valid, pop_valid, popped_id, popped_priority, status_code,
                  entry_count, input ready);
  modport sink (input valid, pop_valid, popped_id, popped_priority, status_code,
                entry_count, output ready);
endinterface

@@ rtl/prq_cell.sv @@
// One storage cell of the sorted queue chain.
module prq_cell (
  input  logic                clk_i,
  input  prq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  prq_pkg::entry_t     left_i,
  input  logic                left_lower_i,
  input  prq_pkg::entry_t     right_i,
  output prq_pkg::entry_t     data_o,
  output logic                lower_o
);

  prq_pkg::entry_t data_q, data_d;

  // The cell yields its place when it is empty or holds a strictly lower priority.
  assign lower_o = !occupied_i || (data_q.prio < ctrl_i.new_entry.prio);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.insert) begin
      if (left_lower_i) begin
        data_d = left_i;
      end else if (lower_o) begin
        data_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.pop) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/priority_ready_queue.sv @@
// Priority ready queue: a sorted chain of cells holding process identifiers.
// The req_i channel carries one command per transfer: an insert of an
// identifier with its priority, or a pop of the head entry. Larger
// priorities leave first, and equal priorities leave in arrival order.
// Every request transfer yields exactly one transfer on rsp_o, which shows
// the popped entry (if any), a status code and the entry count afterward.
// The result is registered and appears in the cycle after the request.
// One request is taken per cycle while rsp_o is taken: each cell compares
// its own priority with the new one and moves one step along the chain in
// the same cycle, so an insert or a pop updates the whole chain at once.
// When rsp_o stalls with a result waiting, req_i.ready drops until it goes.
// Reset empties the queue and clears the pending result; the cell contents
// are not cleared, since only cells below the entry count are ever read.
// An insert into a full queue is dropped and reported with the full status;
// a pop on an empty queue reports the empty status and returns zeros.
module priority_ready_queue (
  input logic         clk_i,
  input logic         rst_ni,
  prq_req_if.sink     req_i,
  prq_rsp_if.source   rsp_o
);

  localparam int unsigned Depth = prq_pkg::QueueDepth;
  localparam int unsigned CntW  = prq_pkg::CountW;

  logic [CntW-1:0]     count_q, count_d;
  logic                rsp_valid_q;
  logic                pop_valid_q;
  prq_pkg::entry_t     popped_q, popped_d;
  prq_pkg::status_e    status_q, status_d;
  logic                accept, is_full, is_empty, do_insert, do_pop;
  prq_pkg::cell_ctrl_t ctrl;
  prq_pkg::entry_t     cell_data [Depth];
  logic [Depth-1:0]    cell_lower;
  logic [Depth-1:0]    cell_occupied;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = (count_q == CntW'(Depth));
  assign is_empty    = (count_q == '0);
  assign do_insert   = accept && (req_i.cmd == prq_pkg::CMD_INSERT) && !is_full;
  assign do_pop      = accept && (req_i.cmd == prq_pkg::CMD_POP) && !is_empty;

  assign ctrl.insert         = do_insert;
  assign ctrl.pop            = do_pop;
  assign ctrl.new_entry.id   = req_i.proc_id;
  assign ctrl.new_entry.prio = req_i.proc_priority;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    prq_pkg::entry_t left_data, right_data;
    logic            left_lower;

    assign cell_occupied[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_data  = ctrl.new_entry;
      assign left_lower = 1'b0;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_lower = cell_lower[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    prq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (cell_occupied[i]),
      .left_i       (left_data),
      .left_lower_i (left_lower),
      .right_i      (right_data),
      .data_o       (cell_data[i]),
      .lower_o      (cell_lower[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = prq_pkg::ST_OK;
    if (req_i.cmd == prq_pkg::CMD_INSERT) begin
      if (is_full) begin
        status_d = prq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = prq_pkg::ST_EMPTY;
      end else begin
        count_d  = count_q - CntW'(1);
        popped_d = cell_data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_valid_q <= do_pop;
      popped_q    <= popped_d;
      status_q    <= status_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.pop_valid       = pop_valid_q;
  assign rsp_o.popped_id       = popped_q.id;
  assign rsp_o.popped_priority = popped_q.prio;
  assign rsp_o.status_code     = status_q;
  assign rsp_o.entry_count     = prq_pkg::EntryCntW'(count_q);

endmodule

@@ rtl/prq_checker.sv @@
// Port-level checker for the priority ready queue, bound to the top level.
`include "assert_macros.svh"

module prq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          pop_valid_i,
  input logic [prq_pkg::IdW-1:0]       popped_id_i,
  input logic [prq_pkg::PrioW-1:0]     popped_priority_i,
  input logic [prq_pkg::StatusW-1:0]   status_code_i,
  input logic [prq_pkg::EntryCntW-1:0] entry_count_i
);

  `ASSERT_STD(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_code_i) && $stable(entry_count_i) && $stable(popped_id_i), "Stalled result changed")
  `ASSERT_STD(a_pop_ok, rsp_valid_i && pop_valid_i |-> status_code_i == prq_pkg::ST_OK, "Popped entry with error status")
  `ASSERT_STD(a_no_pop_zero, rsp_valid_i && !pop_valid_i |-> popped_id_i == '0 && popped_priority_i == '0, "Nonzero entry without a pop")
  `ASSERT_STD(a_empty_count, rsp_valid_i && status_code_i == prq_pkg::ST_EMPTY |-> entry_count_i == '0 && !pop_valid_i, "Empty status with entries held")
  `ASSERT_STD(a_full_count, rsp_valid_i && status_code_i == prq_pkg::ST_FULL |-> entry_count_i == prq_pkg::EntryCntW'(prq_pkg::QueueDepth), "Full status below depth")

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .pop_valid_i       (rsp_o.pop_valid),
  .popped_id_i       (rsp_o.popped_id),
  .popped_priority_i (rsp_o.popped_priority),
  .status_code_i     (rsp_o.status_code),
  .entry_count_i     (rsp_o.entry_count)
);

@@ sim/priority_ready_queue_test.sv @@
// Self-checking testbench for the priority ready queue with random pacing on both channels.
module priority_ready_queue_test;
  import prq_pkg::*;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TailCycles  = 10;

  typedef struct {
    logic             cmd;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    int unsigned      gap;
  } request_t;

  typedef struct packed {
    logic                 pop_valid;
    logic [IdW-1:0]       id;
    logic [PrioW-1:0]     prio;
    status_e              status;
    logic [EntryCntW-1:0] count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  prq_req_if req_if ();
  prq_rsp_if rsp_if ();

  priority_ready_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  request_t    pending_requests[$];
  outcome_t    awaited_results[$];
  int unsigned planned_occupancy;
  int unsigned total_items;

  logic [IdW-1:0]   ready_ids[QueueDepth];
  logic [PrioW-1:0] ready_prios[QueueDepth];
  int unsigned      ready_count;

  int unsigned error_count;
  int unsigned insert_total, full_drops, pop_total, empty_pops, peak_count;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned waited;
  int unsigned stall_left;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic outcome_t schedule_update(logic cmd, logic [IdW-1:0] id,
                                               logic [PrioW-1:0] prio);
    outcome_t    res;
    int unsigned pos;
    res = '0;
    res.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      insert_total++;
      if (ready_count >= QueueDepth) begin
        res.status = ST_FULL;
        full_drops++;
      end else begin
        pos = 0;
        while (pos < ready_count && ready_prios[pos] >= prio) pos++;
        for (int i = ready_count; i > pos; i--) begin
          ready_ids[i]   = ready_ids[i-1];
          ready_prios[i] = ready_prios[i-1];
        end
        ready_ids[pos]   = id;
        ready_prios[pos] = prio;
        ready_count++;
        if (ready_count > peak_count) peak_count = ready_count;
      end
    end else begin
      pop_total++;
      if (ready_count == 0) begin
        res.status = ST_EMPTY;
        empty_pops++;
      end else begin
        res.pop_valid = 1'b1;
        res.id        = ready_ids[0];
        res.prio      = ready_prios[0];
        for (int i = 1; i < ready_count; i++) begin
          ready_ids[i-1]   = ready_ids[i];
          ready_prios[i-1] = ready_prios[i];
        end
        ready_count--;
      end
    end
    res.count = ready_count[EntryCntW-1:0];
    return res;
  endfunction

  function automatic int unsigned draw_wait(int unsigned phase);
    case (phase % 3)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  function automatic void queue_request(logic cmd, logic [IdW-1:0] id, logic [PrioW-1:0] prio);
    request_t req;
    req.cmd  = cmd;
    req.id   = id;
    req.prio = prio;
    req.gap  = draw_wait(pending_requests.size() / 40);
    pending_requests.push_back(req);
    if (cmd == CMD_INSERT && planned_occupancy < QueueDepth) planned_occupancy++;
    if (cmd == CMD_POP && planned_occupancy > 0) planned_occupancy--;
  endfunction

  function automatic logic [PrioW-1:0] pick_prio(int unsigned style);
    case (style)
      0: return PrioW'($urandom_range(0, 3));
      1: return PrioW'($urandom);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic void build_stimulus();
    int unsigned style, extra, len;
    bit          first;
    queue_request(CMD_POP, '1, '1);
    queue_request(CMD_INSERT, 8'hFF, 8'h00);
    queue_request(CMD_INSERT, 8'h00, 8'hFF);
    queue_request(CMD_INSERT, 8'h11, 8'h80);
    queue_request(CMD_INSERT, 8'h22, 8'h80);
    queue_request(CMD_INSERT, 8'h33, 8'h80);
    queue_request(CMD_INSERT, 8'h44, 8'h81);
    queue_request(CMD_INSERT, 8'h55, 8'h7F);
    for (int i = 0; i < 8; i++) queue_request(CMD_POP, IdW'($urandom), PrioW'($urandom));
    first = 1'b1;
    while (pending_requests.size() < RandomItems + 16) begin
      case (first ? 0 : $urandom_range(0, 9))
        0, 1, 2, 3: begin
          style = $urandom_range(0, 2);
          extra = $urandom_range(1, 3);
          while (planned_occupancy < QueueDepth)
            queue_request(CMD_INSERT, IdW'($urandom), pick_prio(style));
          repeat (extra) queue_request(CMD_INSERT, IdW'($urandom), pick_prio(style));
        end
        4, 5: begin
          extra = $urandom_range(1, 2);
          while (planned_occupancy > 0)
            queue_request(CMD_POP, IdW'($urandom), PrioW'($urandom));
          repeat (extra) queue_request(CMD_POP, IdW'($urandom), PrioW'($urandom));
        end
        default: begin
          style = $urandom_range(0, 2);
          len   = $urandom_range(10, 20);
          repeat (len)
            queue_request($urandom_range(0, 1) ? CMD_POP : CMD_INSERT, IdW'($urandom),
                          pick_prio(style));
        end
      endcase
      first = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.cmd           <= CMD_INSERT;
      req_if.proc_id       <= '0;
      req_if.proc_priority <= '0;
      waited               <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_results.push_back(schedule_update(req_if.cmd, req_if.proc_id,
                                                  req_if.proc_priority));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (pending_requests.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (waited < pending_requests[0].gap) begin
          waited       <= waited + 1;
          req_if.valid <= 1'b0;
        end else begin
          req_if.cmd           <= pending_requests[0].cmd;
          req_if.proc_id       <= pending_requests[0].id;
          req_if.proc_priority <= pending_requests[0].prio;
          req_if.valid         <= 1'b1;
          waited               <= 0;
          void'(pending_requests.pop_front());
        end
      end
    end
  end

  task automatic compare_field(string name, logic [15:0] expected, logic [15:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t    want;
    int unsigned pause;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result transfer with none expected, actual status %0h", $time,
                 rsp_if.status_code);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("pop_valid", want.pop_valid, rsp_if.pop_valid);
        compare_field("popped_id", want.id, rsp_if.popped_id);
        compare_field("popped_priority", want.prio, rsp_if.popped_priority);
        compare_field("status_code", want.status, rsp_if.status_code);
        compare_field("entry_count", want.count, rsp_if.entry_count);
      end
      pause = draw_wait(results_seen / 50);
      rsp_if.ready <= (pause == 0);
      stall_left   <= pause;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= (stall_left == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_INSERT;
    req_if.proc_id       = '0;
    req_if.proc_priority = '0;
    rsp_if.ready         = 1'b0;
    build_stimulus();
    total_items = pending_requests.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (results_seen < total_items || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d inserts (%0d dropped while full) and %0d pops (%0d on an empty queue).",
             insert_total, full_drops, pop_total, empty_pops);
    $display("Checked %0d result transfers; peak occupancy %0d of %0d.", results_seen,
             peak_count, QueueDepth);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_req_if.sv
rtl/prq_rsp_if.sv
rtl/prq_cell.sv
rtl/priority_ready_queue.sv
rtl/prq_checker.sv
sim/priority_ready_queue_test.sv
